// ----- rtl/tsrs_pkg.sv -----
package tsrs_pkg;

  localparam int RING_DEPTH = 2048;
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int CMD_W      = 3;
  localparam int STAMP_W    = 32;
  localparam int PAYLOAD_W  = 64;
  localparam int ENTRY_W    = STAMP_W + PAYLOAD_W;
  localparam int HELD_W     = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_EXACT  = 3'd1,
    CMD_AFTER  = 3'd2,
    CMD_BEFORE = 3'd3,
    CMD_OLDEST = 3'd4,
    CMD_NEWEST = 3'd5,
    CMD_COUNT  = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic load;
    logic step;
    logic upper;
    logic prev;
  } srch_ctl_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  pos;
  } srch_sts_t;

  // logical position -> physical slot, pos never exceeds the depth
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                input logic [CNT_W-1:0]  pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

// ----- rtl/tsrs_ram.sv -----
module tsrs_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 96,
  parameter int AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/tsrs_search.sv -----
module tsrs_search import tsrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srch_ctl_t          ctl_i,
  input  logic [CNT_W-1:0]   fill_i,
  input  logic [ADDR_W-1:0]  oldest_i,
  input  logic [STAMP_W-1:0] key_i,
  input  logic [STAMP_W-1:0] rd_stamp_i,
  output srch_sts_t          sts_o
);

  logic [CNT_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] mid_q, mid_d;

  logic             go_right;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] f_rt, l_rt, m_rt, fp_rt;
  logic [CNT_W-1:0] f_lt, l_lt, m_lt, fp_lt;
  logic [ADDR_W-1:0] a_rt, a_lt;

  // both outcomes of the compare are prepared from registers; the read data only selects
  always_comb begin
    half  = len_q >> 1;
    f_rt  = mid_q + CNT_W'(1);
    l_rt  = len_q - half - CNT_W'(1);
    m_rt  = f_rt + (l_rt >> 1);
    f_lt  = first_q;
    l_lt  = half;
    m_lt  = f_lt + (l_lt >> 1);
    fp_rt = (ctl_i.prev && (f_rt != '0)) ? (f_rt - CNT_W'(1)) : f_rt;
    fp_lt = (ctl_i.prev && (f_lt != '0)) ? (f_lt - CNT_W'(1)) : f_lt;
    a_rt  = (l_rt == '0) ? slot_of(oldest_i, fp_rt) : slot_of(oldest_i, m_rt);
    a_lt  = (l_lt == '0) ? slot_of(oldest_i, fp_lt) : slot_of(oldest_i, m_lt);

    go_right = ctl_i.upper ? (rd_stamp_i <= key_i) : (rd_stamp_i < key_i);

    sts_o.done = go_right ? (l_rt == '0) : (l_lt == '0);
    sts_o.addr = go_right ? a_rt : a_lt;
    sts_o.pos  = go_right ? f_rt : f_lt;

    first_d = first_q;
    len_d   = len_q;
    mid_d   = mid_q;
    if (ctl_i.load) begin
      first_d = '0;
      len_d   = fill_i;
      mid_d   = fill_i >> 1;
    end else if (ctl_i.step) begin
      first_d = go_right ? f_rt : f_lt;
      len_d   = go_right ? l_rt : l_lt;
      mid_d   = go_right ? m_rt : m_lt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      len_q   <= '0;
      mid_q   <= '0;
    end else begin
      first_q <= first_d;
      len_q   <= len_d;
      mid_q   <= mid_d;
    end
  end

endmodule

// ----- rtl/timestamped_sample_ring_search_top.sv -----
// Channel  | Direction | Handshake             | Fields
// request  | in        | start / busy          | cmd_i, stamp_i, payload_i, sample_ok_i
// result   | out       | done_o (one cycle)    | found_o, found_stamp_o, found_payload_o,
//          |           |                       | held_count_o, rejected_o
//
// Insert, count and clear: result registered in the cycle after the request, busy stays low.
// Oldest and newest: one store read, then the result state registers the result.
// Time searches: up to floor(log2(held))+1 halving steps of one store read each (single
// read port), the last one also fetching the answer; the result state then registers the
// result. An empty ring goes from the request straight to the result state.
// Reset clears pointers and count; store contents undefined until written. No receiver stall.
module timestamped_sample_ring_search_top import tsrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [STAMP_W-1:0]   stamp_i,
  input  logic [PAYLOAD_W-1:0] payload_i,
  input  logic                 sample_ok_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [STAMP_W-1:0]   found_stamp_o,
  output logic [PAYLOAD_W-1:0] found_payload_o,
  output logic [HELD_W-1:0]    held_count_o,
  output logic                 rejected_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [ADDR_W-1:0]   oldest_q, oldest_d;
  cmd_e                cmd_q, cmd_d;
  logic [STAMP_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]    pos_q, pos_d;

  logic                done_q, done_d;
  logic                found_q, found_d;
  logic [STAMP_W-1:0]  fstamp_q, fstamp_d;
  logic [PAYLOAD_W-1:0] fpay_q, fpay_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic                rej_q, rej_d;

  logic                accept;
  cmd_e                cmd_in;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [CNT_W-1:0]    wpos;
  logic                hit;
  srch_ctl_t           sctl;
  srch_sts_t           ssts;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign cmd_in = cmd_e'(cmd_i);
  assign wpos   = (fill_q == CNT_W'(RING_DEPTH)) ? '0 : fill_q;

  tsrs_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({stamp_i, payload_i}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tsrs_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sctl),
    .fill_i     (fill_q),
    .oldest_i   (oldest_q),
    .key_i      (key_q),
    .rd_stamp_i (rdata[ENTRY_W-1:PAYLOAD_W]),
    .sts_o      (ssts)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    oldest_d = oldest_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    pos_d    = pos_q;
    done_d   = 1'b0;
    found_d  = found_q;
    fstamp_d = fstamp_q;
    fpay_d   = fpay_q;
    held_d   = held_q;
    rej_d    = rej_q;
    we       = 1'b0;
    waddr    = slot_of(oldest_q, wpos);
    re       = 1'b0;
    raddr    = slot_of(oldest_q, '0);
    sctl     = '0;
    sctl.upper = (cmd_q == CMD_AFTER);
    sctl.prev  = (cmd_q == CMD_BEFORE);
    hit      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_in;
          key_d = stamp_i;
          pos_d = '0;
          case (cmd_in)
            CMD_INSERT, CMD_COUNT, CMD_CLEAR: begin
              rej_d = 1'b0;
              if (cmd_in == CMD_INSERT) begin
                if (sample_ok_i && (stamp_i != '0)) begin
                  we = 1'b1;
                  if (fill_q == CNT_W'(RING_DEPTH)) begin
                    oldest_d = slot_of(oldest_q, CNT_W'(1));
                  end else begin
                    fill_d = fill_q + CNT_W'(1);
                  end
                end else begin
                  rej_d = 1'b1;
                end
              end else if (cmd_in == CMD_CLEAR) begin
                fill_d   = '0;
                oldest_d = '0;
              end
              done_d   = 1'b1;
              found_d  = 1'b0;
              fstamp_d = '0;
              fpay_d   = '0;
              held_d   = HELD_W'(fill_d);
            end
            CMD_EXACT, CMD_AFTER, CMD_BEFORE: begin
              re = 1'b1;
              if (fill_q == '0) begin
                state_d = ST_RESULT;
              end else begin
                raddr     = slot_of(oldest_q, fill_q >> 1);
                sctl.load = 1'b1;
                state_d   = ST_SEARCH;
              end
            end
            CMD_OLDEST, CMD_NEWEST: begin
              re = 1'b1;
              if ((cmd_in == CMD_NEWEST) && (fill_q != '0)) begin
                raddr = slot_of(oldest_q, fill_q - CNT_W'(1));
              end
              state_d = ST_RESULT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        sctl.step = 1'b1;
        re        = 1'b1;
        raddr     = ssts.addr;
        if (ssts.done) begin
          pos_d   = ssts.pos;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        case (cmd_q)
          CMD_EXACT:  hit = (pos_q < fill_q) && (rdata[ENTRY_W-1:PAYLOAD_W] == key_q);
          CMD_AFTER:  hit = (pos_q < fill_q);
          CMD_BEFORE: hit = (pos_q != '0);
          default:    hit = (fill_q != '0);
        endcase
        done_d   = 1'b1;
        found_d  = hit;
        fstamp_d = hit ? rdata[ENTRY_W-1:PAYLOAD_W] : '0;
        fpay_d   = hit ? rdata[PAYLOAD_W-1:0] : '0;
        held_d   = HELD_W'(fill_q);
        rej_d    = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      cmd_q    <= CMD_INSERT;
      pos_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      rej_q    <= 1'b0;
      held_q   <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      cmd_q    <= cmd_d;
      pos_q    <= pos_d;
      done_q   <= done_d;
      found_q  <= found_d;
      rej_q    <= rej_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    fstamp_q <= fstamp_d;
    fpay_q   <= fpay_d;
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign found_stamp_o   = fstamp_q;
  assign found_payload_o = fpay_q;
  assign held_count_o    = held_q;
  assign rejected_o      = rej_q;

endmodule

// ----- rtl/tsrs_checker.sv -----
module tsrs_port_asserts import tsrs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [CMD_W-1:0]     cmd_i,
  input logic                 done_o,
  input logic                 found_o,
  input logic [STAMP_W-1:0]   found_stamp_o,
  input logic [PAYLOAD_W-1:0] found_payload_o,
  input logic [HELD_W-1:0]    held_count_o,
  input logic                 rejected_o
);

  // insert, count and clear requests answer in the next cycle, busy staying low
  a_quick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_INSERT || cmd_i == CMD_COUNT || cmd_i == CMD_CLEAR))
    |=> (done_o && !busy))
    else $error("direct request gave no result next cycle");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_clear_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_CLEAR)) |=> (held_count_o == '0))
    else $error("clear left samples held");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_stamp_o == '0 && found_payload_o == '0))
    else $error("miss carries data");

  a_rej_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rejected_o) |-> (!found_o && held_count_o <= HELD_W'(RING_DEPTH)))
    else $error("rejected insert reports a hit");

endmodule

bind timestamped_sample_ring_search_top tsrs_port_asserts u_tsrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cmd_i           (cmd_i),
  .done_o          (done_o),
  .found_o         (found_o),
  .found_stamp_o   (found_stamp_o),
  .found_payload_o (found_payload_o),
  .held_count_o    (held_count_o),
  .rejected_o      (rejected_o)
);

// ----- tb/tsrs_checker.sv -----
module tsrs_checker import tsrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [STAMP_W-1:0]   stamp_i,
  input  logic [PAYLOAD_W-1:0] payload_i,
  input  logic                 sample_ok_i,
  input  logic                 done_i,
  input  logic                 found_i,
  input  logic [STAMP_W-1:0]   found_stamp_i,
  input  logic [PAYLOAD_W-1:0] found_payload_i,
  input  logic [HELD_W-1:0]    held_count_i,
  input  logic                 rejected_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   wraps_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e                 op;
    logic                 found;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic [HELD_W-1:0]    held;
    logic                 rejected;
  } answer_t;

  logic [STAMP_W-1:0]   stamp_mem [RING_DEPTH];
  logic [PAYLOAD_W-1:0] value_mem [RING_DEPTH];
  int unsigned          head_slot;
  int unsigned          held;
  int                   mismatches;
  int                   checked;
  int                   wraps;
  answer_t              answer_q [$];

  function automatic int unsigned slot_at(input int unsigned pos);
    return (head_slot + pos) % RING_DEPTH;
  endfunction

  // halving search; upper selects first stamp > t, else first stamp >= t
  function automatic int unsigned bound_pos(input logic [STAMP_W-1:0] t, input bit upper);
    int unsigned        first;
    int unsigned        len;
    int unsigned        half;
    int unsigned        mid;
    logic [STAMP_W-1:0] s;
    first = 0;
    len   = held;
    while (len > 0) begin
      half = len >> 1;
      mid  = first + half;
      s    = stamp_mem[slot_at(mid)];
      if (upper ? (s <= t) : (s < t)) begin
        first = mid + 1;
        len   = len - half - 1;
      end else begin
        len = half;
      end
    end
    return first;
  endfunction

  function automatic answer_t ring_answer(input cmd_e op, input logic [STAMP_W-1:0] t,
                                          input logic [PAYLOAD_W-1:0] value, input logic ok);
    answer_t     a;
    bit          hit;
    int unsigned pos;
    int unsigned slot;
    hit        = 1'b0;
    pos        = 0;
    a.op       = op;
    a.rejected = 1'b0;
    case (op)
      CMD_INSERT: begin
        if (ok === 1'b1 && t != '0) begin
          slot            = slot_at(held % RING_DEPTH);
          stamp_mem[slot] = t;
          value_mem[slot] = value;
          if (held >= RING_DEPTH) begin
            head_slot = slot_at(1);
            wraps++;
          end else begin
            held++;
          end
        end else begin
          a.rejected = 1'b1;
        end
      end
      CMD_EXACT: begin
        pos = bound_pos(t, 1'b0);
        hit = pos < held && stamp_mem[slot_at(pos)] == t;
      end
      CMD_AFTER: begin
        pos = bound_pos(t, 1'b1);
        hit = pos < held;
      end
      CMD_BEFORE: begin
        pos = bound_pos(t, 1'b0);
        if (pos > 0) begin
          pos--;
          hit = 1'b1;
        end
      end
      CMD_OLDEST: begin
        hit = held > 0;
      end
      CMD_NEWEST: begin
        if (held > 0) begin
          pos = held - 1;
          hit = 1'b1;
        end
      end
      CMD_CLEAR: begin
        held      = 0;
        head_slot = 0;
      end
      default: ;
    endcase
    a.found   = hit;
    a.stamp   = hit ? stamp_mem[slot_at(pos)] : '0;
    a.payload = hit ? value_mem[slot_at(pos)] : '0;
    a.held    = HELD_W'(held);
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      head_slot  = 0;
      held       = 0;
      mismatches = 0;
      checked    = 0;
      wraps      = 0;
    end else begin
      if (done_i !== 1'b0) begin
        if (answer_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with no request waiting", $realtime);
          end
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          checked++;
          if (found_i !== want.found || found_stamp_i !== want.stamp ||
              found_payload_i !== want.payload || held_count_i !== want.held ||
              rejected_i !== want.rejected) begin
            if (mismatches < 10) begin
              $display("%0t: %s mismatch: expected found=%b stamp=%h payload=%h held=%0d rej=%b",
                       $realtime, want.op.name(), want.found, want.stamp, want.payload,
                       want.held, want.rejected);
              $display("    got found=%b stamp=%h payload=%h held=%0d rej=%b",
                       found_i, found_stamp_i, found_payload_i, held_count_i, rejected_i);
            end
            mismatches++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        answer_q.insert(answer_q.size(),
                        ring_answer(cmd_e'(cmd_i), stamp_i, payload_i, sample_ok_i));
      end
    end
    errors_o  <= mismatches;
    pending_o <= answer_q.size();
    checked_o <= checked;
    wraps_o   <= wraps;
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import tsrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  cmd_e                 cmd         = CMD_COUNT;
  logic [STAMP_W-1:0]   stamp       = '0;
  logic [PAYLOAD_W-1:0] payload     = '0;
  logic                 sample_ok   = 1'b0;
  logic                 done;
  logic                 found;
  logic [STAMP_W-1:0]   found_stamp;
  logic [PAYLOAD_W-1:0] found_payload;
  logic [HELD_W-1:0]    held_count;
  logic                 rejected;

  int                   errors;
  int                   pending;
  int                   checked;
  int                   wraps;

  int unsigned          cycles      = 0;
  int unsigned          idle_pct    = 0;
  int unsigned          sent [8];
  int unsigned          refused     = 0;
  logic [STAMP_W-1:0]   last_stamp  = 32'd1000;
  logic [STAMP_W-1:0]   recent [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timestamped_sample_ring_search_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd),
    .stamp_i         (stamp),
    .payload_i       (payload),
    .sample_ok_i     (sample_ok),
    .done_o          (done),
    .found_o         (found),
    .found_stamp_o   (found_stamp),
    .found_payload_o (found_payload),
    .held_count_o    (held_count),
    .rejected_o      (rejected)
  );

  tsrs_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd),
    .stamp_i         (stamp),
    .payload_i       (payload),
    .sample_ok_i     (sample_ok),
    .done_i          (done),
    .found_i         (found),
    .found_stamp_i   (found_stamp),
    .found_payload_i (found_payload),
    .held_count_i    (held_count),
    .rejected_i      (rejected),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .wraps_o         (wraps)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL timestamped_sample_ring_search_top");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance or, when idle_pct draws an idle gap, later
  task automatic issue(input cmd_e c, input logic [STAMP_W-1:0] s,
                       input logic [PAYLOAD_W-1:0] p, input logic ok);
    start     <= 1'b1;
    cmd       <= c;
    stamp     <= s;
    payload   <= p;
    sample_ok <= ok;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    @(negedge clk);
    sent[c]++;
    if (c == CMD_INSERT) begin
      if (ok && s != '0) begin
        last_stamp = s;
        recent.insert(recent.size(), s);
        if (recent.size() > 32) begin
          void'(recent.pop_front());
        end
      end else begin
        refused++;
      end
    end
    if (c == CMD_CLEAR) begin
      recent.delete();
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      start     <= 1'b0;
      cmd       <= cmd_e'($urandom_range(0, 7));
      stamp     <= $urandom;
      payload   <= {$urandom, $urandom};
      sample_ok <= $urandom_range(0, 1);
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [STAMP_W-1:0] query_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (recent.size() != 0 && roll < 40) begin
      return recent[$urandom_range(0, recent.size() - 1)];
    end else if (recent.size() != 0 && roll < 55) begin
      return recent[$urandom_range(0, recent.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    end else if (roll < 65) begin
      return $urandom;
    end else if (roll < 70) begin
      return '0;
    end else if (roll < 75) begin
      return '1;
    end
    return last_stamp + $urandom_range(0, 8) - 4;
  endfunction

  task automatic random_request(input bit filling);
    int unsigned          roll;
    int unsigned          pick;
    logic [STAMP_W-1:0]   s;
    logic [PAYLOAD_W-1:0] p;
    logic                 ok;
    cmd_e                 c;
    roll = $urandom_range(0, 99);
    p    = {$urandom, $urandom};
    ok   = 1'b1;
    if ((filling && roll < 93) || (!filling && (roll < 48 || roll >= 97))) begin
      c    = CMD_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        ok = 1'b0;
        s  = $urandom;
      end else if (pick < 7) begin
        s = '0;
      end else if (pick < 11) begin
        s = $urandom;
      end else if (pick < 15) begin
        s = last_stamp + $urandom_range(5, 100000);
      end else begin
        s = last_stamp + $urandom_range(0, 4);
      end
    end else if (filling) begin
      c = cmd_e'($urandom_range(1, 6));
      s = query_stamp();
    end else begin
      s = query_stamp();
      if (roll < 60) c = CMD_EXACT;
      else if (roll < 70) c = CMD_AFTER;
      else if (roll < 80) c = CMD_BEFORE;
      else if (roll < 85) c = CMD_OLDEST;
      else if (roll < 90) c = CMD_NEWEST;
      else if (roll < 95) c = CMD_COUNT;
      else begin
        c          = CMD_CLEAR;
        last_stamp = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000);
      end
    end
    issue(c, s, p, ok);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned pct, input bit filling);
    idle_pct = pct;
    repeat (n) random_request(filling);
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    idle_pct = 0;
    issue(CMD_EXACT,  32'd5,          '0, 1'b1);
    issue(CMD_AFTER,  32'd0,          '0, 1'b1);
    issue(CMD_BEFORE, 32'hFFFF_FFFF,  '0, 1'b1);
    issue(CMD_OLDEST, '0,             '0, 1'b0);
    issue(CMD_NEWEST, '0,             '0, 1'b0);
    issue(CMD_COUNT,  '0,             '0, 1'b0);
    issue(CMD_INSERT, 32'd100,        64'h1234, 1'b0);
    issue(CMD_INSERT, 32'd0,          '1, 1'b1);
    issue(CMD_INSERT, 32'd10,         '1, 1'b1);
    issue(CMD_INSERT, 32'd20,         '0, 1'b1);
    issue(CMD_INSERT, 32'd20,         64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
    issue(CMD_BEFORE, 32'hFFFF_FFFF,  '0, 1'b0);
    issue(CMD_INSERT, 32'hFFFF_FFFF,  64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
    issue(CMD_EXACT,  32'd20,         '0, 1'b1);
    issue(CMD_EXACT,  32'd15,         '0, 1'b1);
    issue(CMD_EXACT,  32'd0,          '0, 1'b1);
    issue(CMD_AFTER,  32'd20,         '0, 1'b1);
    issue(CMD_AFTER,  32'hFFFF_FFFF,  '0, 1'b1);
    issue(CMD_AFTER,  32'd0,          '0, 1'b1);
    issue(CMD_BEFORE, 32'd10,         '0, 1'b1);
    issue(CMD_BEFORE, 32'd20,         '0, 1'b1);
    issue(CMD_OLDEST, '0,             '0, 1'b1);
    issue(CMD_NEWEST, '0,             '0, 1'b1);
    issue(CMD_CLEAR,  '1,             '1, 1'b1);
    issue(CMD_COUNT,  '0,             '0, 1'b1);
    // hold off until every directed request has answered
    drain();

    random_phase(200, 0,  1'b0);
    random_phase(200, 51, 1'b0);
    // mostly inserts: grows the ring well beyond the query phases
    random_phase(400, 0,  1'b1);
    random_phase(200, 36, 1'b0);
    random_phase(175, 0,  1'b0);

    repeat (30) @(negedge clk);
    $display("sent %0d inserts (%0d refused), %0d exact, %0d after, %0d before, %0d other",
             sent[CMD_INSERT], refused, sent[CMD_EXACT], sent[CMD_AFTER], sent[CMD_BEFORE],
             sent[CMD_OLDEST] + sent[CMD_NEWEST] + sent[CMD_COUNT] + sent[CMD_CLEAR]);
    $display("%0d results checked, %0d inserts overwrote the oldest sample of a full ring",
             checked, wraps);
    if (errors == 0 && pending == 0) begin
      $display("PASS timestamped_sample_ring_search_top");
    end else begin
      $display("FAIL timestamped_sample_ring_search_top");
    end
    $finish;
  end

endmodule
